// ----- hdl/mexp_pkg.sv -----
// Shared widths, beat type and tag codes for the modular exponentiation core.
package mexp_pkg;
  localparam int OPERAND_BITS = 32;
  localparam int CHAIN_CELLS = OPERAND_BITS;

  localparam logic TAG_ACC = 1'b0;
  localparam logic TAG_SQ = 1'b1;

  typedef logic [OPERAND_BITS-1:0] operand_t;

  // One beat travelling down the multiplier chain.
  typedef struct packed {
    logic valid;
    logic tag;
    operand_t r;
    operand_t a;
    operand_t b;
  } mexp_beat_t;
endpackage

// ----- hdl/mexp_cell.sv -----
// One interleaved modular multiplication step: r = (2r + a_msb * b) mod m.
module mexp_cell
  import mexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  operand_t   modulus,
  input  mexp_beat_t din,
  output mexp_beat_t dout
);
  logic [OPERAND_BITS+1:0] t;
  logic [OPERAND_BITS+1:0] d1;
  logic [OPERAND_BITS+1:0] d2;
  logic [OPERAND_BITS+1:0] m_ext;
  operand_t r_next;

  always_comb begin
    m_ext = {2'b00, modulus};
    t = {1'b0, din.r, 1'b0} + (din.a[OPERAND_BITS-1] ? {2'b00, din.b} : '0);
    d1 = t - m_ext;
    d2 = t - {m_ext[OPERAND_BITS:0], 1'b0};
    // Since r < m and b < m, t < 3m, so at most two subtractions are needed.
    if (t >= {m_ext[OPERAND_BITS:0], 1'b0}) begin
      r_next = d2[OPERAND_BITS-1:0];
    end else if (t >= m_ext) begin
      r_next = d1[OPERAND_BITS-1:0];
    end else begin
      r_next = t[OPERAND_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.tag <= din.tag;
    dout.r <= r_next;
    dout.a <= {din.a[OPERAND_BITS-2:0], 1'b0};
    dout.b <= din.b;
  end
endmodule

// ----- hdl/mexp_chain.sv -----
// Row of multiplication cells forming a pipelined modular multiplier.
module mexp_chain
  import mexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  operand_t   modulus,
  input  mexp_beat_t din,
  output mexp_beat_t dout
);
  mexp_beat_t link [CHAIN_CELLS+1];

  assign link[0] = din;

  for (genvar i = 0; i < CHAIN_CELLS; i++) begin : g_cell
    mexp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .modulus (modulus),
      .din     (link[i]),
      .dout    (link[i+1])
    );
  end

  assign dout = link[CHAIN_CELLS];
endmodule

// ----- hdl/modular_exponentiation_core.sv -----
// Top level: square-and-multiply controller around a cell-chain modular multiplier.
//
// Usage: write the modulus on the cfg channel (cfg_valid/cfg_ready, cfg_ready is
// always high) while the core is idle; writes of 0 or 1 are ignored. Each input
// beat (in_valid high, in_stall low) carries base_value and exponent; one output
// beat returns power_result = base_value^exponent mod modulus.
// The multiplier is a chain of OPERAND_BITS cells, one multiplier bit per cell,
// each cell registering the beat, so a product comes back after passing every cell.
// The base is first reduced (one pass), then each exponent bit up to the highest set
// bit issues the accumulator product (only if the bit is set) and the square, and
// waits for both to pass the chain; the finish state then loads the output register
// and raises out_valid. One item is worked at a time: the core takes no new item
// until the controller is through with the last one. Once a result sits in the
// output register the core accepts the next item. If out_stall holds a finished
// result, the next result waits in the controller until the output register frees
// up; in_stall stays high meanwhile.
// Reset sets the modulus to 2, empties the chain and drops out_valid.
module modular_exponentiation_core
  import mexp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic [31:0] base_value,
  input  logic [31:0] exponent,
  output logic     out_valid,
  input  logic     out_stall,
  output logic [31:0] power_result
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED_WAIT = 3'd1;
  localparam logic [2:0] S_ISSUE_ACC = 3'd2;
  localparam logic [2:0] S_ISSUE_SQ = 3'd3;
  localparam logic [2:0] S_LOOP_WAIT = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  operand_t modulus;
  operand_t acc;
  operand_t sq;
  operand_t expo;
  mexp_beat_t chain_in;
  mexp_beat_t chain_out;
  operand_t cfg_masked;

  assign cfg_ready = 1'b1;
  assign cfg_masked = cfg_data[OPERAND_BITS-1:0];
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= operand_t'(2);
    end else if (cfg_valid && cfg_masked >= operand_t'(2)) begin
      modulus <= cfg_masked;
    end
  end

  always_comb begin
    chain_in.valid = 1'b0;
    chain_in.tag = TAG_SQ;
    chain_in.r = '0;
    chain_in.a = sq;
    chain_in.b = sq;
    unique case (state)
      S_IDLE: begin
        // Reduce the base: base * 1 mod m.
        chain_in.valid = in_valid;
        chain_in.a = base_value[OPERAND_BITS-1:0];
        chain_in.b = operand_t'(1);
      end
      S_ISSUE_ACC: begin
        chain_in.valid = expo[0];
        chain_in.tag = TAG_ACC;
        chain_in.a = acc;
      end
      S_ISSUE_SQ: chain_in.valid = 1'b1;
      default: chain_in.valid = 1'b0;
    endcase
  end

  mexp_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .din     (chain_in),
    .dout    (chain_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            acc <= operand_t'(1);
            expo <= exponent[OPERAND_BITS-1:0];
            state <= S_RED_WAIT;
          end
        end
        S_RED_WAIT: begin
          if (chain_out.valid) begin
            sq <= chain_out.r;
            state <= (expo == '0) ? S_FINISH : S_ISSUE_ACC;
          end
        end
        S_ISSUE_ACC: state <= S_ISSUE_SQ;
        S_ISSUE_SQ: state <= S_LOOP_WAIT;
        S_LOOP_WAIT: begin
          if (chain_out.valid) begin
            if (chain_out.tag == TAG_ACC) begin
              acc <= chain_out.r;
            end else begin
              sq <= chain_out.r;
              expo <= expo >> 1;
              state <= ((expo >> 1) == '0) ? S_FINISH : S_ISSUE_ACC;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            power_result <= 32'(acc);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(power_result))
    else $error("stalled result changed or vanished");

  a_chain_only_busy: assert property (@(posedge clk) disable iff (rst)
    chain_out.valid |-> (state == S_RED_WAIT || state == S_LOOP_WAIT))
    else $error("multiplier result arrived while controller not waiting");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result presented without finishing an item");
endmodule
